[rtl/pde_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pde_pkg: shared types and character functions
// Queue entry layout, character codes and the percent-pair decoder used by
// the front and back parts of the percent decoder and escaper.
// ----------------------------------------------------------------------------
package pde_pkg;

  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [QPTR_W-1:0] QPTR_ONE  = QPTR_W'(1);
  localparam logic [QCNT_W-1:0] QCNT_ONE  = QCNT_W'(1);
  localparam logic [QCNT_W-1:0] QCNT_FULL = QCNT_W'(QDEPTH);

  localparam logic [7:0] CH_PERCENT   = 8'h25;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_AMP       = 8'h26;
  localparam logic [7:0] CH_HASH      = 8'h23;
  localparam logic [7:0] CH_SEMI      = 8'h3B;
  localparam logic [7:0] CH_A         = 8'h61;
  localparam logic [7:0] CH_M         = 8'h6D;
  localparam logic [7:0] CH_P         = 8'h70;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_PLUS      = 8'h2B;
  localparam logic [7:0] CH_MINUS     = 8'h2D;
  localparam logic [7:0] CH_NUL       = 8'h00;

  // Escape sequence "&amp;" is five bytes, index 0..4.
  localparam logic [2:0] AMP_LAST = 3'd4;

  // Pending-percent codes.
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_PCT  = 2'd1;
  localparam logic [1:0] PEND_ONE  = 2'd2;

  // One queued job: up to two characters to emit, plus the end-of-string mark.
  // valid1 implies valid0; no valid character with eos set means a bare marker.
  typedef struct packed {
    logic [7:0] char0;
    logic       valid0;
    logic [7:0] char1;
    logic       valid1;
    logic       eos;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Hex digit value; bit 4 flags a valid digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // Base-16 conversion of a two-character pair, cut to 8 bits.
  function automatic logic [7:0] decode_pair(input logic [7:0] c1, input logic [7:0] c2);
    logic [4:0] d1;
    logic [4:0] d2;
    logic [7:0] v;
    d1 = hex_value(c1);
    d2 = hex_value(c2);
    v  = 8'd0;
    if (d1[4]) begin
      v = d2[4] ? {d1[3:0], d2[3:0]} : {4'd0, d1[3:0]};
    end else if (is_space(c1) || c1 == CH_PLUS) begin
      v = d2[4] ? {4'd0, d2[3:0]} : 8'd0;
    end else if (c1 == CH_MINUS) begin
      v = d2[4] ? (8'd0 - {4'd0, d2[3:0]}) : 8'd0;
    end
    return v;
  endfunction

  function automatic logic is_escape(input logic [7:0] c);
    return (c == CH_BACKSLASH) || (c == CH_SQUOTE) || (c == CH_DQUOTE) ||
           (c == CH_AMP) || (c == CH_HASH) || (c == CH_SEMI);
  endfunction

  function automatic logic [7:0] amp_byte(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = CH_AMP;
      3'd1:    r = CH_A;
      3'd2:    r = CH_M;
      3'd3:    r = CH_P;
      default: r = CH_SEMI;
    endcase
    return r;
  endfunction

endpackage

[rtl/pde_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pde_front: input classifier
// Tracks the pending percent and held character, decodes percent pairs and
// the stopped-output condition, and builds at most one job per input item.
// ----------------------------------------------------------------------------
module pde_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  output logic              in_ready,
  input  pde_pkg::q_status_t q_status,
  output logic              push,
  output pde_pkg::job_t     job
);

  logic [1:0] pend;
  logic [7:0] held;
  logic       stopped;

  logic [1:0] pend_next;
  logic [7:0] held_next;
  logic       stopped_next;
  logic [7:0] cand_a;
  logic [7:0] cand_b;
  logic       req_a;
  logic       req_b;
  logic       keep_a;
  logic       keep_b;
  logic       stop_a;
  logic       stop_b;
  logic       accept;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    pend_next = pend;
    held_next = held;
    cand_a    = in_byte;
    cand_b    = held;
    req_a     = 1'b0;
    req_b     = 1'b0;
    if (!stopped) begin
      case (pend)
        pde_pkg::PEND_NONE: begin
          if (in_byte == pde_pkg::CH_PERCENT) begin
            pend_next = pde_pkg::PEND_PCT;
          end else begin
            req_a = 1'b1;
          end
        end
        pde_pkg::PEND_PCT: begin
          held_next = in_byte;
          pend_next = pde_pkg::PEND_ONE;
        end
        default: begin
          cand_a    = pde_pkg::decode_pair(held, in_byte);
          req_a     = 1'b1;
          pend_next = pde_pkg::PEND_NONE;
          held_next = 8'd0;
        end
      endcase
    end
    // Short percent at end of string: flush as plain characters.
    if (in_last && pend_next == pde_pkg::PEND_PCT) begin
      cand_a = pde_pkg::CH_PERCENT;
      req_a  = 1'b1;
    end else if (in_last && pend_next == pde_pkg::PEND_ONE) begin
      cand_a = pde_pkg::CH_PERCENT;
      cand_b = held_next;
      req_a  = 1'b1;
      req_b  = 1'b1;
    end
  end

  // A zero character stops output for the rest of the string.
  always_comb begin
    stop_a = stopped || (req_a && cand_a == pde_pkg::CH_NUL);
    keep_a = req_a && !stop_a;
    stop_b = stop_a || (req_b && cand_b == pde_pkg::CH_NUL);
    keep_b = req_b && !stop_b;
    stopped_next = stop_b;
  end

  always_comb begin
    job.char0  = cand_a;
    job.valid0 = keep_a;
    job.char1  = cand_b;
    job.valid1 = keep_b;
    job.eos    = in_last;
  end

  assign push = accept && (keep_a || in_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend    <= pde_pkg::PEND_NONE;
      held    <= 8'd0;
      stopped <= 1'b0;
    end else if (accept) begin
      if (in_last) begin
        pend    <= pde_pkg::PEND_NONE;
        held    <= 8'd0;
        stopped <= 1'b0;
      end else begin
        pend    <= pend_next;
        held    <= held_next;
        stopped <= stopped_next;
      end
    end
  end

endmodule

[rtl/pde_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pde_queue: job queue
// Small FIFO of jobs between the classifier and the output sequencer.
// ----------------------------------------------------------------------------
module pde_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  pde_pkg::job_t      push_job,
  input  logic               pop,
  output pde_pkg::job_t      head,
  output pde_pkg::q_status_t status
);

  pde_pkg::job_t                  entries [pde_pkg::QDEPTH];
  logic [pde_pkg::QPTR_W-1:0]     wr_ptr;
  logic [pde_pkg::QPTR_W-1:0]     rd_ptr;
  logic [pde_pkg::QCNT_W-1:0]     count;

  assign status.full  = (count == pde_pkg::QCNT_FULL);
  assign status.empty = (count == '0);
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + pde_pkg::QPTR_ONE;
      if (pop)  rd_ptr <= rd_ptr + pde_pkg::QPTR_ONE;
      case ({push, pop})
        2'b10:   count <= count + pde_pkg::QCNT_ONE;
        2'b01:   count <= count - pde_pkg::QCNT_ONE;
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/pde_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pde_back: output sequencer
// Walks the head job one output byte per cycle while out_ready is high,
// expanding escapes into "&amp;", and releases the job on its last byte.
// ----------------------------------------------------------------------------
module pde_back (
  input  logic               clk,
  input  logic               rst,
  input  pde_pkg::job_t      head,
  input  pde_pkg::q_status_t q_status,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               byte_valid,
  output logic               end_of_string,
  output logic               last_in_run
);

  logic       sel;
  logic [2:0] idx;

  logic [7:0] ch;
  logic       esc;
  logic       unit_end;
  logic       job_end;
  logic       take;

  assign out_valid = !q_status.empty;
  assign take      = out_valid && out_ready;

  always_comb begin
    ch       = sel ? head.char1 : head.char0;
    esc      = head.valid0 && pde_pkg::is_escape(ch);
    unit_end = !esc || (idx == pde_pkg::AMP_LAST);
    job_end  = unit_end && (sel || !head.valid1);
    if (!head.valid0)  out_byte = pde_pkg::CH_NUL;
    else if (esc)      out_byte = pde_pkg::amp_byte(idx);
    else               out_byte = ch;
    byte_valid    = head.valid0;
    last_in_run   = job_end;
    end_of_string = job_end && head.eos;
  end

  assign pop = take && job_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= 1'b0;
      idx <= 3'd0;
    end else if (take) begin
      if (job_end) begin
        sel <= 1'b0;
        idx <= 3'd0;
      end else if (unit_end) begin
        sel <= 1'b1;
        idx <= 3'd0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

endmodule

[rtl/percent_decode_and_escape.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// percent_decode_and_escape: streaming percent decoder and escaper
// Decodes percent pairs in a byte stream and escapes special characters
// as "&amp;", with one end-marked result closing every string.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Signals                          Contents
//  -------  ---  -------------------------------  ------------------------------
//  s        in   s_tvalid s_tready s_tdata s_tlast source byte, last byte of string
//  m        out  m_tvalid m_tready m_tdata m_tuser output byte, byte_valid,
//                m_tlast                          last_in_run, end_of_string
//
//  Flow: an input item is classified in the cycle it is accepted; its results
//  leave one byte per cycle while m_tready is high: a plain byte yields one output
//  byte, an escaped character five, and a string end with a flushed short percent
//  up to six. The output sequencer (one byte per cycle) sets the rate.
//  Reset: synchronous, active high; clears the pending percent, held character,
//  stopped flag and the job queue.
//  Stalls: a four-entry job queue separates input and output, so input keeps
//  flowing while an output item waits, until the queue fills.
// ----------------------------------------------------------------------------
module percent_decode_and_escape (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,   // last_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic [1:0] m_tuser,   // [0] byte_valid, [1] last_in_run
  output logic       m_tlast    // end_of_string
);

  pde_pkg::job_t      push_job;
  pde_pkg::job_t      head;
  pde_pkg::q_status_t q_status;
  logic               push;
  logic               pop;
  logic               byte_valid;
  logic               last_in_run;

  // Classify each item and hold the percent state.
  pde_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_byte  (s_tdata),
    .in_last  (s_tlast),
    .in_ready (s_tready),
    .q_status (q_status),
    .push     (push),
    .job      (push_job)
  );

  // Buffer jobs so either side can stall alone.
  pde_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  // Expand the head job into output bytes.
  pde_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .q_status      (q_status),
    .pop           (pop),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_byte      (m_tdata),
    .byte_valid    (byte_valid),
    .end_of_string (m_tlast),
    .last_in_run   (last_in_run)
  );

  assign m_tuser = {last_in_run, byte_valid};

  // End of string always closes the run of its item.
  a_eos_closes_run: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> m_tuser[1])
    else $error("end of string without last_in_run");

  // A bare marker appears only as the end of a string and carries zero.
  a_bare_marker: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tlast && m_tdata == 8'h00))
    else $error("bare marker outside string end");

  // Every ampersand starts an escape, so an 'a' follows it.
  a_amp_sequence: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tuser[0] && m_tdata == pde_pkg::CH_AMP)
      |=> (m_tvalid && m_tdata == pde_pkg::CH_A))
    else $error("escape sequence broken");

  // No item is taken while the queue is full.
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_status.full |-> !s_tready)
    else $error("input accepted into full queue");

endmodule
